// ===== hdl/pdc_pkg.sv =====
// Shared types, codes and constants of the PI duty controller.
// Used by the front decoder, the back sequencer and the top level.
`timescale 1ns / 1ps

package pdc_pkg;

  // Queue depths (top-level parameter defaults)
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Input function codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_PRESET = 2'd2;

  // Motor mode codes
  localparam logic [1:0] MODE_ACCEL = 2'd1;
  localparam logic [1:0] MODE_BRAKE = 2'd2;

  // Loop kind codes
  localparam logic LOOP_PI = 1'b0;

  // Configuration register indexes
  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [1:0] REG_PWM_PERIOD = 2'd2;
  localparam logic [1:0] REG_BIPOLAR    = 2'd3;

  // Configuration reset values
  localparam logic [15:0] PROP_GAIN_RST  = 16'd256;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd256;
  localparam logic [15:0] PWM_PERIOD_RST = 16'd1000;
  localparam logic        BIPOLAR_RST    = 1'b0;

  // Q8.8 duty limits and scale
  localparam logic [15:0] DUTY_MIN_Q = 16'd12800;  // 50.0
  localparam logic [15:0] DUTY_MAX_Q = 16'd24320;  // 95.0
  localparam logic [15:0] HUNDRED_Q  = 16'd25600;  // 100.0
  localparam logic [15:0] OFFSET_Q   = 16'd12800;  // 50.0
  localparam logic [8:0]  PRESET_OFS = 9'd50;

  // Divide by 100 as multiply by ceil(2^30/100), exact for values below 2^23
  localparam logic [23:0] RECIP_100  = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  typedef enum logic [2:0] {
    OP_PI,
    OP_PASS,
    OP_CLEAR,
    OP_PRESET,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic signed [7:0] err;
    logic [7:0]        duty_req;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  duty_percent;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic        integ_frozen;
  } res_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_step_gain;
    logic [15:0] pwm_period;
    logic        bipolar_mode;
  } cfg_t;

endpackage

// ===== hdl/pdc_fifo.sv =====
// Small synchronous queue of fixed-width words, used for commands and results.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module pdc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/pdc_front.sv =====
// Front decoder: classifies an input item into an operation and a signed error.
// Depends on pdc_pkg (codes, cmd_t).
`timescale 1ns / 1ps

module pdc_front (
  input  logic [1:0]    func,
  input  logic [1:0]    motor_mode,
  input  logic [6:0]    accel_request,
  input  logic [6:0]    brake_request,
  input  logic          loop_kind,
  input  logic [7:0]    duty_request,
  output pdc_pkg::cmd_t cmd
);

  always_comb begin
    cmd.duty_req = duty_request;

    // Error: positive accel, negated brake, zero otherwise
    unique case (motor_mode)
      pdc_pkg::MODE_ACCEL: cmd.err = $signed({1'b0, accel_request});
      pdc_pkg::MODE_BRAKE: cmd.err = -$signed({1'b0, brake_request});
      default:             cmd.err = '0;
    endcase

    unique case (func)
      pdc_pkg::FUNC_TICK:   cmd.op = (loop_kind == pdc_pkg::LOOP_PI) ? pdc_pkg::OP_PI
                                                                    : pdc_pkg::OP_PASS;
      pdc_pkg::FUNC_CLEAR:  cmd.op = pdc_pkg::OP_CLEAR;
      pdc_pkg::FUNC_PRESET: cmd.op = pdc_pkg::OP_PRESET;
      default:              cmd.op = pdc_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== hdl/pdc_back.sv =====
// Back sequencer: runs the PI update, duty clamp and compare scaling per command.
// Depends on pdc_pkg (cmd_t, res_t, cfg_t, constants).
`timescale 1ns / 1ps

module pdc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pdc_pkg::cfg_t cfg,
  input  pdc_pkg::cmd_t cmd_rdata,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output pdc_pkg::res_t res_wdata,
  output logic          res_push,
  input  logic          res_full
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DUTY,
    ST_CMUL,
    ST_EMIT
  } state_t;

  localparam logic signed [33:0] DMin = 34'(pdc_pkg::DUTY_MIN_Q);
  localparam logic signed [33:0] DMax = 34'(pdc_pkg::DUTY_MAX_Q);
  localparam logic signed [33:0] DOfs = 34'(pdc_pkg::OFFSET_Q);
  localparam logic signed [31:0] IMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] IMin = 32'sh8000_0000;

  state_t               state_r, state_nxt;
  pdc_pkg::cmd_t        cmd_r, cmd_nxt;
  logic signed [23:0]   prod_i_r, prod_i_nxt;
  logic signed [23:0]   prod_p_r, prod_p_nxt;
  logic                 frozen_r, frozen_nxt;
  logic signed [31:0]   integ_r, integ_nxt;
  logic [15:0]          last_duty_r, last_duty_nxt;
  logic [31:0]          a_raw_r, a_raw_nxt;
  logic [31:0]          b_raw_r, b_raw_nxt;

  logic signed [23:0]   ki_ext, kp_ext, err_ext;
  logic signed [32:0]   isum;
  logic signed [31:0]   isat;
  logic signed [8:0]    preset_diff;
  logic signed [33:0]   dsum;
  logic [15:0]          pi_duty, pass_duty, pass_raw;
  logic [47:0]          qa_full, qb_full;
  logic [15:0]          qa, qb;

  assign ki_ext  = $signed({8'b0, cfg.integ_step_gain});
  assign kp_ext  = $signed({8'b0, cfg.prop_gain});
  assign err_ext = {{16{cmd_r.err[7]}}, cmd_r.err};

  // Saturating integral update
  assign isum = {integ_r[31], integ_r} + {{9{prod_i_r[23]}}, prod_i_r};
  assign isat = (isum[32] != isum[31]) ? (isum[32] ? IMin : IMax) : isum[31:0];

  assign preset_diff = $signed({1'b0, cmd_r.duty_req}) - $signed(pdc_pkg::PRESET_OFS);

  // PI duty before and after the clamp
  assign dsum = {{10{prod_p_r[23]}}, prod_p_r} + {{2{integ_r[31]}}, integ_r} + DOfs;
  always_comb begin
    if (dsum > DMax) begin
      pi_duty = pdc_pkg::DUTY_MAX_Q;
    end else if (dsum < DMin) begin
      pi_duty = pdc_pkg::DUTY_MIN_Q;
    end else begin
      pi_duty = dsum[15:0];
    end
  end

  assign pass_raw = {cmd_r.duty_req, 8'b0};
  always_comb begin
    if (pass_raw > pdc_pkg::DUTY_MAX_Q) begin
      pass_duty = pdc_pkg::DUTY_MAX_Q;
    end else if (pass_raw < pdc_pkg::DUTY_MIN_Q) begin
      pass_duty = pdc_pkg::DUTY_MIN_Q;
    end else begin
      pass_duty = pass_raw;
    end
  end

  // Divide by 25600: drop 8 bits, then reciprocal multiply for the /100
  assign qa_full = {24'b0, a_raw_r[31:8]} * {24'b0, pdc_pkg::RECIP_100};
  assign qb_full = {24'b0, b_raw_r[31:8]} * {24'b0, pdc_pkg::RECIP_100};
  assign qa      = qa_full[pdc_pkg::RECIP_SHIFT +: 16];
  assign qb      = qb_full[pdc_pkg::RECIP_SHIFT +: 16];

  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;
  assign res_push = (state_r == ST_EMIT);

  always_comb begin
    res_wdata.duty_percent = last_duty_r[14:8];
    res_wdata.compare_a    = qa;
    res_wdata.compare_b    = cfg.bipolar_mode ? qa : qb;
    res_wdata.integ_frozen = frozen_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    prod_i_nxt    = prod_i_r;
    prod_p_nxt    = prod_p_r;
    frozen_nxt    = frozen_r;
    integ_nxt     = integ_r;
    last_duty_nxt = last_duty_r;
    a_raw_nxt     = a_raw_r;
    b_raw_nxt     = b_raw_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_nxt   = cmd_rdata;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_i_nxt = ki_ext * err_ext;
        prod_p_nxt = kp_ext * err_ext;
        frozen_nxt = (cmd_r.op == pdc_pkg::OP_PI) &&
                     ((last_duty_r >= pdc_pkg::DUTY_MAX_Q) ||
                      (last_duty_r <= pdc_pkg::DUTY_MIN_Q));
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        unique case (cmd_r.op)
          pdc_pkg::OP_PI:     if (!frozen_r) integ_nxt = isat;
          pdc_pkg::OP_CLEAR:  integ_nxt = '0;
          pdc_pkg::OP_PRESET: integ_nxt = {{15{preset_diff[8]}}, preset_diff, 8'b0};
          default:            integ_nxt = integ_r;
        endcase
        state_nxt = ST_DUTY;
      end
      ST_DUTY: begin
        unique case (cmd_r.op)
          pdc_pkg::OP_PI:   last_duty_nxt = pi_duty;
          pdc_pkg::OP_PASS: last_duty_nxt = pass_duty;
          default:          last_duty_nxt = last_duty_r;
        endcase
        state_nxt = ST_CMUL;
      end
      ST_CMUL: begin
        a_raw_nxt = {16'b0, last_duty_r} * {16'b0, cfg.pwm_period};
        b_raw_nxt = {16'b0, pdc_pkg::HUNDRED_Q - last_duty_r} * {16'b0, cfg.pwm_period};
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integ_r     <= '0;
      last_duty_r <= pdc_pkg::DUTY_MIN_Q;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      last_duty_r <= last_duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    prod_i_r <= prod_i_nxt;
    prod_p_r <= prod_p_nxt;
    frozen_r <= frozen_nxt;
    a_raw_r  <= a_raw_nxt;
    b_raw_r  <= b_raw_nxt;
  end

endmodule

// ===== hdl/pi_duty_controller_antiwindup.sv =====
// Top level of the PI duty controller with anti-windup clamp.
// Depends on pdc_pkg, pdc_front, pdc_fifo and pdc_back.
`timescale 1ns / 1ps

// Usage
//   Input queue: drive in_* fields and raise in_push; a transaction is taken
//   at a clock edge where in_push is high and in_full is low. Each input
//   transaction is a control tick, an integral clear or an integral preset.
//   Result queue: while out_empty is low the oldest result sits on out_*;
//   raise out_pop to take it. Every input transaction yields one result.
//   Configuration: write gains, PWM period and bipolar mode through
//   cfg_we/cfg_index/cfg_data only while no transaction is in flight.
// Sequencing
//   A command waits in a small queue, then the back sequencer takes it through
//   its dependent steps in order (fetch, gain multiplies, integral update,
//   duty clamp, compare multiplies, reciprocal divide and push). The single
//   sequencer takes no new command until it has pushed the last result,
//   and it waits in its push step while the result queue is full.
// Reset and stall
//   Synchronous active-low reset empties both queues, zeroes the integral,
//   sets the held duty to 50 percent and loads the register defaults.
//   If the receiver stops popping, results fill the output queue, the
//   sequencer holds its finished result, then the command queue fills and
//   in_full rises. Nothing is dropped.

module pi_duty_controller_antiwindup #(
  parameter int CmdDepth = pdc_pkg::CMD_DEPTH,
  parameter int ResDepth = pdc_pkg::RES_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input queue
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_motor_mode,
  input  logic [6:0]  in_accel_request,
  input  logic [6:0]  in_brake_request,
  input  logic        in_loop_kind,
  input  logic [7:0]  in_duty_request,
  // result queue
  output logic        out_empty,
  input  logic        out_pop,
  output logic [6:0]  out_duty_percent,
  output logic [15:0] out_compare_a,
  output logic [15:0] out_compare_b,
  output logic        out_integ_frozen,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CmdW = $bits(pdc_pkg::cmd_t);
  localparam int ResW = $bits(pdc_pkg::res_t);

  pdc_pkg::cfg_t cfg_r, cfg_nxt;
  pdc_pkg::cmd_t front_cmd, cmd_rdata;
  pdc_pkg::res_t res_wdata, res_rdata;
  logic          cmd_empty, cmd_pop;
  logic          res_push, res_full;

  // Configuration registers: plain writes, no read-back
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pdc_pkg::REG_PROP_GAIN:  cfg_nxt.prop_gain       = cfg_data;
        pdc_pkg::REG_INTEG_GAIN: cfg_nxt.integ_step_gain = cfg_data;
        pdc_pkg::REG_PWM_PERIOD: cfg_nxt.pwm_period      = cfg_data;
        pdc_pkg::REG_BIPOLAR:    cfg_nxt.bipolar_mode    = cfg_data[0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= pdc_pkg::PROP_GAIN_RST;
      cfg_r.integ_step_gain <= pdc_pkg::INTEG_GAIN_RST;
      cfg_r.pwm_period      <= pdc_pkg::PWM_PERIOD_RST;
      cfg_r.bipolar_mode    <= pdc_pkg::BIPOLAR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: classify the request into an operation and a signed error
  pdc_front u_front (
    .func          (in_func),
    .motor_mode    (in_motor_mode),
    .accel_request (in_accel_request),
    .brake_request (in_brake_request),
    .loop_kind     (in_loop_kind),
    .duty_request  (in_duty_request),
    .cmd           (front_cmd)
  );

  // Command queue decouples the front from the sequencer
  pdc_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  // Back: PI update, clamp and compare scaling
  pdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_rdata (cmd_rdata),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_wdata (res_wdata),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // Result queue: hold finished results while the receiver stalls
  pdc_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_duty_percent = res_rdata.duty_percent;
  assign out_compare_a    = res_rdata.compare_a;
  assign out_compare_b    = res_rdata.compare_b;
  assign out_integ_frozen = res_rdata.integ_frozen;

endmodule

// ===== hdl/pdc_checker.sv =====
// Port-level checker for the PI duty controller, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module pdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [6:0]  out_duty_percent,
  input logic [15:0] out_compare_a,
  input logic [15:0] out_compare_b,
  input logic        out_integ_frozen
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for input
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");

  // Every visible duty lies within the clamp
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
      !out_empty |-> (out_duty_percent >= 7'd50) && (out_duty_percent <= 7'd95))
    else $error("duty outside clamp range");

  // A waiting result holds while not popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && !out_pop) |=> (!out_empty && $stable(out_duty_percent) &&
                                    $stable(out_compare_a) && $stable(out_compare_b) &&
                                    $stable(out_integ_frozen)))
    else $error("waiting result changed or vanished");

endmodule

bind pi_duty_controller_antiwindup pdc_checker u_pdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_push          (in_push),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_duty_percent (out_duty_percent),
  .out_compare_a    (out_compare_a),
  .out_compare_b    (out_compare_b),
  .out_integ_frozen (out_integ_frozen)
);

// ===== verif/pdc_duty_checker.sv =====
// Scoreboard for the PI duty controller: watches the input, result and register ports.
// Predicts each result from its own copy of the controller state and compares it field by field.
// Depends on pdc_pkg for codes, limits and the result layout.
`timescale 1ns / 1ps

module pdc_duty_checker
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_motor_mode,
  input  logic [6:0]  in_accel_request,
  input  logic [6:0]  in_brake_request,
  input  logic        in_loop_kind,
  input  logic [7:0]  in_duty_request,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [6:0]  out_duty_percent,
  input  logic [15:0] out_compare_a,
  input  logic [15:0] out_compare_b,
  input  logic        out_integ_frozen,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int     REPORT_LIMIT = 10;
  localparam longint INTEG_MAX = (longint'(1) <<< 31) - 1;
  localparam longint INTEG_MIN = -(longint'(1) <<< 31);

  res_t expected_duty_q[$];

  // register copies
  logic [15:0] kp;
  logic [15:0] ki;
  logic [15:0] period;
  logic        bipolar;

  // controller state: integral is signed Q24.8, held duty is Q8.8
  logic signed [31:0] integ_acc;
  logic [15:0]        held_duty;

  function automatic res_t advance_controller(input logic [1:0] func, input logic [1:0] mode,
                                              input logic [6:0] accel, input logic [6:0] brake,
                                              input logic kind, input logic [7:0] dreq);
    longint err;
    longint duty;
    longint sum;
    longint d;
    longint p;
    longint cmp_a;
    longint cmp_b;
    logic   frozen;
    res_t   r;
    err    = 0;
    frozen = 1'b0;
    case (func)
      FUNC_CLEAR:  integ_acc = '0;
      FUNC_PRESET: integ_acc = 32'((longint'(dreq) - longint'(PRESET_OFS)) * 256);
      FUNC_TICK: begin
        if (mode == MODE_ACCEL) begin
          err = longint'(accel);
        end else if (mode == MODE_BRAKE) begin
          err = -longint'(brake);
        end
        if (kind == LOOP_PI) begin
          // anti-windup: hold the integral while the last duty sits on a limit
          frozen = (held_duty >= DUTY_MAX_Q) || (held_duty <= DUTY_MIN_Q);
          if (!frozen) begin
            sum = longint'(integ_acc) + longint'(ki) * err;
            if (sum > INTEG_MAX) sum = INTEG_MAX;
            if (sum < INTEG_MIN) sum = INTEG_MIN;
            integ_acc = 32'(sum);
          end
          duty = longint'(kp) * err + longint'(integ_acc) + longint'(OFFSET_Q);
        end else begin
          duty = longint'(dreq) * 256;
        end
        if (duty > longint'(DUTY_MAX_Q)) duty = longint'(DUTY_MAX_Q);
        if (duty < longint'(DUTY_MIN_Q)) duty = longint'(DUTY_MIN_Q);
        held_duty = 16'(duty);
      end
      default: ;
    endcase
    d     = longint'(held_duty);
    p     = longint'(period);
    cmp_a = (d * p) / longint'(HUNDRED_Q);
    cmp_b = bipolar ? cmp_a : ((longint'(HUNDRED_Q) - d) * p) / longint'(HUNDRED_Q);
    r.duty_percent = held_duty[14:8];
    r.compare_a    = cmp_a[15:0];
    r.compare_b    = cmp_b[15:0];
    r.integ_frozen = frozen;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      kp        = PROP_GAIN_RST;
      ki        = INTEG_GAIN_RST;
      period    = PWM_PERIOD_RST;
      bipolar   = BIPOLAR_RST;
      integ_acc = '0;
      held_duty = DUTY_MIN_Q;
      expected_duty_q.delete();
    end else begin
      // retire the oldest expectation on each popped result
      if (out_pop && !out_empty) begin
        if (expected_duty_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected result duty %0d cmp_a %0d cmp_b %0d frozen %0b",
                     $time, out_duty_percent, out_compare_a, out_compare_b, out_integ_frozen);
        end else begin
          want = expected_duty_q.pop_front();
          if (want.duty_percent !== out_duty_percent || want.compare_a !== out_compare_a ||
              want.compare_b !== out_compare_b || want.integ_frozen !== out_integ_frozen) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: mismatch exp duty %0d a %0d b %0d frz %0b, got %0d %0d %0d %0b",
                       $time, want.duty_percent, want.compare_a, want.compare_b,
                       want.integ_frozen, out_duty_percent, out_compare_a, out_compare_b,
                       out_integ_frozen);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:  kp      = cfg_data;
          REG_INTEG_GAIN: ki      = cfg_data;
          REG_PWM_PERIOD: period  = cfg_data;
          REG_BIPOLAR:    bipolar = cfg_data[0];
          default: ;
        endcase
      end
      if (in_push && !in_full)
        expected_duty_q.push_back(advance_controller(in_func, in_motor_mode, in_accel_request,
                                                     in_brake_request, in_loop_kind,
                                                     in_duty_request));
    end
    pending = expected_duty_q.size();
  end

endmodule

// ===== verif/tb_pi_duty_controller_antiwindup.sv =====
// Top of the PI duty controller testbench: clock, reset, stimulus, result sink and verdict.
// Instantiates pi_duty_controller_antiwindup beside pdc_duty_checker; needs pdc_pkg.
`timescale 1ns / 1ps

module tb_pi_duty_controller_antiwindup;
  import pdc_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic       LOOP_PASS  = 1'b1;

  localparam int RESET_CYCLES  = 10;
  localparam int DRAIN_CYCLES  = 12;   // settling wait once every expected result is back
  localparam int LONG_HOLD     = 60;   // receiver hold-off that backs up both queues
  localparam int PHASE_ITEMS   = 45;
  localparam int WINDUP_PAIRS  = 40;   // unfrozen max-error ticks per direction
  localparam int TIMEOUT_NS    = 5_000_000;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] mode;
    logic [6:0] accel;
    logic [6:0] brake;
    logic       kind;
    logic [7:0] dreq;
  } tick_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_func;
  logic [1:0]  in_motor_mode;
  logic [6:0]  in_accel_request;
  logic [6:0]  in_brake_request;
  logic        in_loop_kind;
  logic [7:0]  in_duty_request;
  logic        out_empty;
  logic        out_pop;
  logic [6:0]  out_duty_percent;
  logic [15:0] out_compare_a;
  logic [15:0] out_compare_b;
  logic        out_integ_frozen;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;

  // shared with the result sink; set at time 0, then written nonblocking at falling edges
  logic gaps_on;
  int   holds_asked;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pi_duty_controller_antiwindup i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_func          (in_func),
    .in_motor_mode    (in_motor_mode),
    .in_accel_request (in_accel_request),
    .in_brake_request (in_brake_request),
    .in_loop_kind     (in_loop_kind),
    .in_duty_request  (in_duty_request),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_duty_percent (out_duty_percent),
    .out_compare_a    (out_compare_a),
    .out_compare_b    (out_compare_b),
    .out_integ_frozen (out_integ_frozen),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  pdc_duty_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_func          (in_func),
    .in_motor_mode    (in_motor_mode),
    .in_accel_request (in_accel_request),
    .in_brake_request (in_brake_request),
    .in_loop_kind     (in_loop_kind),
    .in_duty_request  (in_duty_request),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_duty_percent (out_duty_percent),
    .out_compare_a    (out_compare_a),
    .out_compare_b    (out_compare_b),
    .out_integ_frozen (out_integ_frozen),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  function automatic tick_req_t make_tick(input logic [1:0] func, input logic [1:0] mode,
                                          input logic [6:0] accel, input logic [6:0] brake,
                                          input logic kind, input logic [7:0] dreq);
    tick_req_t t;
    t.func  = func;
    t.mode  = mode;
    t.accel = accel;
    t.brake = brake;
    t.kind  = kind;
    t.dreq  = dreq;
    return t;
  endfunction

  // Mostly control ticks with small errors so the duty lives inside the window and the
  // integral really moves; the rest are clears, presets, spare codes and full-range values.
  function automatic tick_req_t random_tick();
    tick_req_t t;
    t.func  = ($urandom_range(0, 9) < 7) ? FUNC_TICK : 2'($urandom_range(1, 3));
    t.mode  = 2'($urandom_range(0, 3));
    t.accel = $urandom_range(0, 1) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 12));
    t.brake = $urandom_range(0, 1) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 12));
    t.kind  = ($urandom_range(0, 2) == 0) ? LOOP_PASS : LOOP_PI;
    t.dreq  = $urandom_range(0, 1) ? 8'($urandom_range(51, 94)) : 8'($urandom_range(0, 255));
    return t;
  endfunction

  // Offer one transaction from a falling edge and hold it until the block takes it.
  // Push stays high afterwards so back-to-back transactions need no extra edge.
  task automatic push_tick(input tick_req_t t);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_push          <= 1'b1;
    in_func          <= t.func;
    in_motor_mode    <= t.mode;
    in_accel_request <= t.accel;
    in_brake_request <= t.brake;
    in_loop_kind     <= t.kind;
    in_duty_request  <= t.dreq;
    do @(posedge clk); while (in_full);
  endtask

  // Drop push, let every expected result come back, then rewrite all four registers.
  task automatic reconfigure(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] period, input logic bip);
    @(negedge clk);
    in_push <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_PROP_GAIN;  cfg_data <= kp;
    @(negedge clk);
    cfg_index <= REG_INTEG_GAIN; cfg_data <= ki;
    @(negedge clk);
    cfg_index <= REG_PWM_PERIOD; cfg_data <= period;
    @(negedge clk);
    cfg_index <= REG_BIPOLAR;    cfg_data <= {15'd0, bip};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) push_tick(random_tick());
  endtask

  // Alternate a pass-through tick (duty inside the window, so the next PI tick is not
  // frozen) with a full-scale PI tick; the integral climbs or falls in large steps.
  task automatic drive_windup(input logic [1:0] mode);
    push_tick(make_tick(FUNC_CLEAR, MODE_IDLE, 7'd0, 7'd0, LOOP_PI, 8'd0));
    repeat (WINDUP_PAIRS) begin
      push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'($urandom), 7'($urandom), LOOP_PASS,
                          8'($urandom_range(51, 94))));
      push_tick(make_tick(FUNC_TICK, mode, 7'd127, 7'd127, LOOP_PI, 8'($urandom)));
    end
    repeat (3) push_tick(make_tick(FUNC_TICK, mode, 7'd127, 7'd127, LOOP_PI, 8'd0));
  endtask

  // Result sink: pops whenever it is not idling. A long hold is counted here, in cycles,
  // when the stimulus raises holds_asked.
  initial begin : result_sink
    int idle_left;
    int holds_served;
    idle_left    = 0;
    holds_served = 0;
    out_pop      = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        idle_left    = LONG_HOLD - 1;
        out_pop     <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_pop <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(1, 9) - 1;
        out_pop  <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    // every input known from time zero; reset held for a fixed count of cycles
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_func          = FUNC_TICK;
    in_motor_mode    = MODE_IDLE;
    in_accel_request = '0;
    in_brake_request = '0;
    in_loop_kind     = LOOP_PI;
    in_duty_request  = '0;
    cfg_we           = 1'b0;
    cfg_index        = REG_PROP_GAIN;
    cfg_data         = '0;
    gaps_on          = 1'b1;
    holds_asked      = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset register values.
    // Start-up: held duty is 50, so the first PI ticks stay frozen.
    push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'd0, 7'd0, LOOP_PI, 8'd0));
    push_tick(make_tick(FUNC_TICK, MODE_ACCEL, 7'd127, 7'd0, LOOP_PI, 8'd0));
    // held at the upper limit: still frozen
    push_tick(make_tick(FUNC_TICK, MODE_ACCEL, 7'd0, 7'd127, LOOP_PI, 8'd255));
    // pass-through with out-of-window requests clamps both ways
    push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'd0, 7'd0, LOOP_PASS, 8'd0));
    push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'd0, 7'd0, LOOP_PASS, 8'd255));
    push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'd0, 7'd0, LOOP_PASS, 8'd70));
    // inside the window: integration runs, then full brake drives it negative
    push_tick(make_tick(FUNC_TICK, MODE_ACCEL, 7'd10, 7'd0, LOOP_PI, 8'd0));
    push_tick(make_tick(FUNC_TICK, MODE_BRAKE, 7'd0, 7'd127, LOOP_PI, 8'd0));
    // spare motor mode acts as idle even with large requests
    push_tick(make_tick(FUNC_TICK, MODE_SPARE, 7'd127, 7'd127, LOOP_PI, 8'd0));
    push_tick(make_tick(FUNC_CLEAR, MODE_ACCEL, 7'd127, 7'd127, LOOP_PI, 8'd255));
    // preset below 50 leaves a negative integral
    push_tick(make_tick(FUNC_PRESET, MODE_IDLE, 7'd0, 7'd0, LOOP_PI, 8'd0));
    push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'd0, 7'd0, LOOP_PASS, 8'd60));
    push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'd0, 7'd0, LOOP_PI, 8'd0));
    push_tick(make_tick(FUNC_PRESET, MODE_BRAKE, 7'd0, 7'd0, LOOP_PI, 8'd255));
    // spare function code changes nothing
    push_tick(make_tick(FUNC_SPARE, MODE_ACCEL, 7'd127, 7'd127, LOOP_PASS, 8'd255));
    push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'd0, 7'd0, LOOP_PASS, 8'd95));
    push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'd0, 7'd0, LOOP_PASS, 8'd50));
    push_tick(make_tick(FUNC_TICK, MODE_IDLE, 7'd0, 7'd0, LOOP_PASS, 8'd94));
    push_tick(make_tick(FUNC_TICK, MODE_BRAKE, 7'd0, 7'd1, LOOP_PI, 8'd0));

    // Bipolar compares; the sink holds off long enough to fill both queues and raise full.
    reconfigure(16'd256, 16'd256, 16'd1000, 1'b1);
    holds_asked <= holds_asked + 1;
    run_random(PHASE_ITEMS);

    // gain and period extremes
    reconfigure(16'd0, 16'd0, 16'hFFFF, 1'b0);
    run_random(PHASE_ITEMS);
    reconfigure(16'hFFFF, 16'hFFFF, 16'd1, 1'b1);
    run_random(PHASE_ITEMS);
    // zero period: compares come out as zero
    reconfigure(16'd64, 16'd16, 16'd0, 1'b0);
    run_random(PHASE_ITEMS);
    reconfigure(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)), 1'($urandom));
    run_random(PHASE_ITEMS);

    // large integral swings in both directions
    reconfigure(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    drive_windup(MODE_ACCEL);
    drive_windup(MODE_BRAKE);

    // last stretch runs flat out on both sides
    reconfigure(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                16'($urandom_range(1, 65535)), 1'($urandom));
    gaps_on <= 1'b0;
    run_random(PHASE_ITEMS);

    @(negedge clk);
    in_push <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_pi_duty_controller_antiwindup passed");
    end else begin
      $display("tb_pi_duty_controller_antiwindup failed");
    end
    $finish;
  end

  // hard stop if the block hangs on either handshake
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_pi_duty_controller_antiwindup failed");
    $finish;
  end

endmodule
